>>> rtl/core/tcp_passive_seq_tracker_unit_macros.svh
`ifndef TCP_PASSIVE_SEQ_TRACKER_UNIT_MACROS_SVH
`define TCP_PASSIVE_SEQ_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled while in reset
`define TPST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, disabled while in reset
`define TPST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tpst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpst_pkg;

    localparam int unsigned SEQ_W = 32;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned SPAN_W = LEN_W + 1;

    typedef enum logic [1:0] {
        OP_OPEN    = 2'd0,
        OP_HS_ACK  = 2'd1,
        OP_SEGMENT = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PHASE_IDLE        = 2'd0,
        PHASE_SYN_RCVD    = 2'd1,
        PHASE_ESTABLISHED = 2'd2,
        PHASE_CLOSE_WAIT  = 2'd3
    } phase_t;

    typedef struct packed {
        op_t                op;
        logic [SEQ_W-1:0]   seg_seq;
        logic [SEQ_W-1:0]   seg_ack;
        logic               flag_syn;
        logic               flag_ack;
        logic               flag_fin;
        logic [LEN_W-1:0]   payload_len;
        logic [SEQ_W-1:0]   initial_seq;
    } hdr_t;

    typedef struct packed {
        phase_t             phase;
        logic [SEQ_W-1:0]   local_next;
        logic [SEQ_W-1:0]   remote_next;
    } conn_t;

    typedef struct packed {
        logic               accepted;
        logic [SEQ_W-1:0]   expected_ack;
        phase_t             conn_state;
        logic [SEQ_W-1:0]   local_next;
        logic [SEQ_W-1:0]   remote_next;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/tpst_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpst_hdr_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [tpst_pkg::SEQ_W-1:0] seg_seq;
    logic [tpst_pkg::SEQ_W-1:0] seg_ack;
    logic                       flag_syn;
    logic                       flag_ack;
    logic                       flag_fin;
    logic [tpst_pkg::LEN_W-1:0] payload_len;
    logic [tpst_pkg::SEQ_W-1:0] initial_seq;

    modport source (
        output valid, op, seg_seq, seg_ack, flag_syn, flag_ack, flag_fin,
               payload_len, initial_seq,
        input  ready
    );
    modport sink (
        input  valid, op, seg_seq, seg_ack, flag_syn, flag_ack, flag_fin,
               payload_len, initial_seq,
        output ready
    );
endinterface

interface tpst_result_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [tpst_pkg::SEQ_W-1:0] expected_ack;
    logic [1:0]                 conn_state;
    logic [tpst_pkg::SEQ_W-1:0] local_next;
    logic [tpst_pkg::SEQ_W-1:0] remote_next;

    modport source (
        output valid, accepted, expected_ack, conn_state, local_next, remote_next,
        input  ready
    );
    modport sink (
        input  valid, accepted, expected_ack, conn_state, local_next, remote_next,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/tpst_update.sv
`timescale 1ns / 1ps
`default_nettype none

module tpst_update (
    input  var tpst_pkg::hdr_t    hdr,
    input  var tpst_pkg::conn_t   conn,
    output tpst_pkg::conn_t       conn_next,
    output tpst_pkg::result_t     res
);

    logic [tpst_pkg::SPAN_W-1:0] span;
    logic                        seq_match;
    logic [tpst_pkg::SEQ_W-1:0]  remote_adv;
    logic                        hs_ok;

    assign span = {1'b0, hdr.payload_len}
                + {{(tpst_pkg::SPAN_W-1){1'b0}}, hdr.flag_syn}
                + {{(tpst_pkg::SPAN_W-1){1'b0}}, hdr.flag_fin};
    assign seq_match  = (hdr.seg_seq == conn.remote_next);
    assign remote_adv = conn.remote_next
                      + {{(tpst_pkg::SEQ_W-tpst_pkg::SPAN_W){1'b0}}, span};
    assign hs_ok = (conn.phase == tpst_pkg::PHASE_SYN_RCVD) && hdr.flag_ack
                && (hdr.seg_ack == conn.local_next);

    // next connection state
    always_comb
    begin
        conn_next = conn;
        unique case (hdr.op)
            tpst_pkg::OP_OPEN:
            begin
                conn_next.phase       = tpst_pkg::PHASE_SYN_RCVD;
                conn_next.local_next  = hdr.initial_seq + 32'd1;
                conn_next.remote_next = hdr.seg_seq + 32'd1;
            end
            tpst_pkg::OP_HS_ACK:
            begin
                if (hs_ok)
                begin
                    conn_next.phase = tpst_pkg::PHASE_ESTABLISHED;
                end
            end
            tpst_pkg::OP_SEGMENT:
            begin
                if (seq_match)
                begin
                    conn_next.remote_next = remote_adv;
                    if (hdr.flag_fin)
                    begin
                        conn_next.phase = tpst_pkg::PHASE_CLOSE_WAIT;
                    end
                end
            end
            default:
            begin
                conn_next = conn;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        res.expected_ack = seq_match ? remote_adv : conn.remote_next;
        res.conn_state   = conn_next.phase;
        res.local_next   = conn_next.local_next;
        res.remote_next  = conn_next.remote_next;
        unique case (hdr.op)
            tpst_pkg::OP_OPEN:    res.accepted = 1'b1;
            tpst_pkg::OP_HS_ACK:  res.accepted = hs_ok;
            tpst_pkg::OP_SEGMENT: res.accepted = seq_match;
            default:              res.accepted = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tcp_passive_seq_tracker_unit.sv
// Sequence tracker for one passively opened TCP connection.
// hdr carries parsed segment headers (op, sequence, ack, flags, payload
// length, local initial sequence); result returns one item per header:
// accepted flag, ack to send, connection phase and both next-sequence values.
// Both channels move an item on a clock edge where valid and ready are high.
// A taken header is held in the input register, then in the result register.
// Throughput: one header per cycle unless result stalls; the update is a
// 32-bit compare and add between the input register and the result
// register, with the connection state updated as the item moves into the
// result register.
// When result is stalled, the result register holds its item and the input
// register holds one more; hdr.ready drops only when both are full.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// connection to idle with both sequence values zero.
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_passive_seq_tracker_unit_macros.svh"

module tcp_passive_seq_tracker_unit (
    input  wire             clk,
    input  wire             rst_n,
    tpst_hdr_if.sink        hdr,
    tpst_result_if.source   result
);

    logic                s1_valid_reg;
    tpst_pkg::hdr_t      s1_hdr_reg;
    logic                out_valid_reg;
    tpst_pkg::result_t   out_res_reg;
    tpst_pkg::conn_t     conn_reg;

    tpst_pkg::hdr_t      hdr_in;
    tpst_pkg::conn_t     conn_next;
    tpst_pkg::result_t   res_next;
    logic                s1_adv;
    logic                in_take;

    assign hdr_in = '{
        op:          tpst_pkg::op_t'(hdr.op),
        seg_seq:     hdr.seg_seq,
        seg_ack:     hdr.seg_ack,
        flag_syn:    hdr.flag_syn,
        flag_ack:    hdr.flag_ack,
        flag_fin:    hdr.flag_fin,
        payload_len: hdr.payload_len,
        initial_seq: hdr.initial_seq
    };

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign hdr.ready = !s1_valid_reg || s1_adv;
    assign in_take   = hdr.valid && hdr.ready;

    tpst_update u_update (
        .hdr       (s1_hdr_reg),
        .conn      (conn_reg),
        .conn_next (conn_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            conn_reg      <= '{phase: tpst_pkg::PHASE_IDLE,
                               local_next: '0, remote_next: '0};
        end
        else
        begin
            if (hdr.ready)
            begin
                s1_valid_reg <= hdr.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                conn_reg      <= conn_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_hdr_reg <= hdr_in;
        end
        if (s1_adv)
        begin
            out_res_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_res_reg.accepted;
    assign result.expected_ack = out_res_reg.expected_ack;
    assign result.conn_state   = out_res_reg.conn_state;
    assign result.local_next   = out_res_reg.local_next;
    assign result.remote_next  = out_res_reg.remote_next;

    `TPST_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_reg, "result register not loaded")
    `TPST_ASSERT_NEXT(a_open_syn_rcvd, s1_adv && (s1_hdr_reg.op == tpst_pkg::OP_OPEN), conn_reg.phase == tpst_pkg::PHASE_SYN_RCVD, "open did not enter syn-received")
    `TPST_ASSERT_NEXT(a_conn_hold, !s1_adv, $stable(conn_reg), "connection state moved without an item")
    `TPST_ASSERT_NOW(a_out_matches_conn, out_valid_reg && $past(s1_adv), (out_res_reg.local_next == conn_reg.local_next) && (out_res_reg.remote_next == conn_reg.remote_next) && (out_res_reg.conn_state == conn_reg.phase), "result disagrees with connection state")

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import tpst_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int TOTAL_ITEMS = 1150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tpst_hdr_if    hdr_ch ();
    tpst_result_if res_ch ();

    tcp_passive_seq_tracker_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .hdr    (hdr_ch),
        .result (res_ch)
    );

    always #10 clk = ~clk;

    // tracked connection, mirrors the block
    phase_t      tr_phase = PHASE_IDLE;
    logic [31:0] tr_local = '0;
    logic [31:0] tr_remote = '0;

    result_t     expected_results[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          burst_left = 1;
    int          gap_max = 0;
    int          stall_cycles = 0;
    logic        hold_req = 1'b0;

    int          rx_mode = 0;
    int          rx_left = 0;
    int          hold_left = 0;
    int unsigned rx_cyc = 0;

    initial
    begin
        hdr_ch.valid       = 1'b0;
        hdr_ch.op          = OP_OPEN;
        hdr_ch.seg_seq     = '0;
        hdr_ch.seg_ack     = '0;
        hdr_ch.flag_syn    = 1'b0;
        hdr_ch.flag_ack    = 1'b0;
        hdr_ch.flag_fin    = 1'b0;
        hdr_ch.payload_len = '0;
        hdr_ch.initial_seq = '0;
        res_ch.ready       = 1'b0;
    end

    function automatic result_t predict_result(input hdr_t h);
        logic [31:0] span;
        logic        in_order;
        result_t     r;
        span = 32'(h.payload_len) + 32'(h.flag_syn) + 32'(h.flag_fin);
        in_order = (h.seg_seq == tr_remote);
        // ack is computed from the state before the update
        r.expected_ack = in_order ? tr_remote + span : tr_remote;
        r.accepted = 1'b0;
        case (h.op)
            OP_OPEN:
            begin
                tr_local = h.initial_seq + 32'd1;
                tr_remote = h.seg_seq + 32'd1;
                tr_phase = PHASE_SYN_RCVD;
                r.accepted = 1'b1;
            end
            OP_HS_ACK:
            begin
                if (tr_phase == PHASE_SYN_RCVD && h.flag_ack && h.seg_ack == tr_local)
                begin
                    tr_phase = PHASE_ESTABLISHED;
                    r.accepted = 1'b1;
                end
            end
            OP_SEGMENT:
            begin
                if (in_order)
                begin
                    tr_remote = tr_remote + span;
                    if (h.flag_fin)
                        tr_phase = PHASE_CLOSE_WAIT;
                    r.accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.conn_state = tr_phase;
        r.local_next = tr_local;
        r.remote_next = tr_remote;
        return r;
    endfunction

    function automatic hdr_t make_hdr(input op_t op, input logic [31:0] seq,
                                      input logic [31:0] ack, input logic syn,
                                      input logic ackf, input logic fin,
                                      input logic [15:0] len, input logic [31:0] isn);
        hdr_t h;
        h.op = op;
        h.seg_seq = seq;
        h.seg_ack = ack;
        h.flag_syn = syn;
        h.flag_ack = ackf;
        h.flag_fin = fin;
        h.payload_len = len;
        h.initial_seq = isn;
        return h;
    endfunction

    // mostly small payloads, some full range and the extremes
    function automatic logic [15:0] rand_len();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick < 7)
            return 16'($urandom_range(1500, 0));
        else if (pick < 9)
            return 16'($urandom);
        else
            return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic send_header(input hdr_t h);
        int gap;
        hdr_ch.valid       <= 1'b1;
        hdr_ch.op          <= h.op;
        hdr_ch.seg_seq     <= h.seg_seq;
        hdr_ch.seg_ack     <= h.seg_ack;
        hdr_ch.flag_syn    <= h.flag_syn;
        hdr_ch.flag_ack    <= h.flag_ack;
        hdr_ch.flag_fin    <= h.flag_fin;
        hdr_ch.payload_len <= h.payload_len;
        hdr_ch.initial_seq <= h.initial_seq;
        @(posedge clk);
        while (!hdr_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_result(h));
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            // valid stays high when no gap follows
            if (gap > 0)
            begin
                hdr_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(12, 1);
        end
    endtask

    task automatic test_directed_cases();
        gap_max = 3;
        // op 1 while idle is rejected even with a matching ack
        send_header(make_hdr(OP_HS_ACK, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0));
        // op 2 while idle still runs the sequence check
        send_header(make_hdr(OP_SEGMENT, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_UNUSED, 32'd0, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF,
                             32'hFFFFFFFF));
        // open with all-ones values, flags and length ignored, both sides wrap to 0
        send_header(make_hdr(OP_OPEN, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1,
                             16'hFFFF, 32'hFFFFFFFF));
        send_header(make_hdr(OP_HS_ACK, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_HS_ACK, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_HS_ACK, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_HS_ACK, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_SEGMENT, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 16'hFFFF, 32'd0));
        send_header(make_hdr(OP_SEGMENT, 32'd5, 32'd0, 1'b0, 1'b1, 1'b0, 16'd10, 32'd0));
        send_header(make_hdr(OP_SEGMENT, 32'h10000, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_UNUSED, $urandom, $urandom, 1'b0, 1'b0, 1'b0, 16'd7, $urandom));
        send_header(make_hdr(OP_SEGMENT, 32'h10000, 32'd0, 1'b0, 1'b1, 1'b1, 16'd100, 32'd0));
        // in-order segment in close-wait, maximum span
        send_header(make_hdr(OP_SEGMENT, 32'h10065, 32'd0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 32'd0));
        // reopen from close-wait
        send_header(make_hdr(OP_OPEN, 32'hFFFFFFFE, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0));
        // FIN straight from syn-received, remote wraps
        send_header(make_hdr(OP_SEGMENT, 32'hFFFFFFFF, 32'd0, 1'b0, 1'b0, 1'b1, 16'd1, 32'd0));
        send_header(make_hdr(OP_HS_ACK, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_OPEN, 32'h80000000, 32'hFFFFFFFF, 1'b0, 1'b1, 1'b0, 16'd0,
                             32'h7FFFFFFF));
        send_header(make_hdr(OP_HS_ACK, 32'd0, 32'h80000000, 1'b0, 1'b1, 1'b0, 16'd0, 32'd0));
        send_header(make_hdr(OP_SEGMENT, 32'h80000001, 32'd0, 1'b1, 1'b0, 1'b0, 16'd1, 32'd0));
    endtask

    // receiver holds off while the sender keeps pushing in-order segments
    task automatic test_input_stall();
        gap_max = 0;
        burst_left = 1000;
        hold_req <= 1'b1;
        repeat (40)
            send_header(make_hdr(OP_SEGMENT, tr_remote, $urandom, 1'b0, 1'b1, 1'b0,
                                 rand_len(), $urandom));
        burst_left = 1;
    endtask

    task automatic test_random_sessions(input int target);
        int          n_seg;
        logic [31:0] seq;
        logic        good;
        logic        fin;
        while (items_sent < target)
        begin
            case ($urandom_range(3, 0))
                0: gap_max = 0;
                1: gap_max = 2;
                2: gap_max = 5;
                default: gap_max = 8;
            endcase
            if ($urandom_range(99, 0) < 85)
            begin
                seq = ($urandom_range(4, 0) == 0) ? 32'hFFFFFFFF - $urandom_range(3000, 0)
                                                  : $urandom;
                send_header(make_hdr(OP_OPEN, seq, $urandom, 1'($urandom), 1'($urandom),
                                     1'($urandom), rand_len(), $urandom));
                if ($urandom_range(9, 0) != 0)
                begin
                    good = ($urandom_range(4, 0) != 0);
                    send_header(make_hdr(OP_HS_ACK, tr_remote, good ? tr_local : $urandom,
                                         1'($urandom), good ? 1'b1 : 1'($urandom), 1'b0,
                                         rand_len(), $urandom));
                end
                n_seg = $urandom_range(12, 1);
                for (int k = 0; k < n_seg; k++)
                begin
                    if ($urandom_range(9, 0) < 8)
                        seq = tr_remote;
                    else
                        seq = $urandom_range(1, 0) ? $urandom : tr_remote + 32'd1;
                    fin = (k == n_seg - 1) && ($urandom_range(1, 0) == 1);
                    send_header(make_hdr(OP_SEGMENT, seq, $urandom,
                                         $urandom_range(19, 0) == 0, 1'($urandom), fin,
                                         rand_len(), $urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_header(make_hdr(op_t'($urandom_range(3, 0)),
                                         $urandom_range(1, 0) ? tr_remote : $urandom,
                                         $urandom_range(1, 0) ? tr_local : $urandom,
                                         1'($urandom), 1'($urandom), 1'($urandom),
                                         rand_len(), $urandom));
            end
        end
    endtask

    // receiver: random modes, plus a long hold-off on request
    always @(posedge clk)
    begin
        rx_cyc++;
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req <= 1'b0;
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(3, 0);
            rx_left = $urandom_range(400, 50);
        end
        else
            rx_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(3, 0) != 0);
                2: res_ch.ready <= ((rx_cyc % 5) < 3);
                default: res_ch.ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: result item with nothing expected: acc=%0d ack=%h st=%0d ln=%h rn=%h",
                             $realtime, res_ch.accepted, res_ch.expected_ack,
                             res_ch.conn_state, res_ch.local_next, res_ch.remote_next);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.accepted !== want.accepted ||
                    res_ch.expected_ack !== want.expected_ack ||
                    res_ch.conn_state !== want.conn_state ||
                    res_ch.local_next !== want.local_next ||
                    res_ch.remote_next !== want.remote_next)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch exp acc=%0d ack=%h st=%0d ln=%h rn=%h got acc=%0d ack=%h st=%0d ln=%h rn=%h",
                                 $realtime, want.accepted, want.expected_ack,
                                 want.conn_state, want.local_next, want.remote_next,
                                 res_ch.accepted, res_ch.expected_ack, res_ch.conn_state,
                                 res_ch.local_next, res_ch.remote_next);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_input_stall();
        test_random_sessions(TOTAL_ITEMS);
        hdr_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> tcp_passive_seq_tracker_unit.f
+incdir+rtl/core
rtl/core/tpst_pkg.sv
rtl/core/tpst_if.sv
rtl/core/tpst_update.sv
rtl/core/tcp_passive_seq_tracker_unit.sv
tb/tb.sv
